/* rtl/complex_arithmetic_unit_assert.svh */
// Assertion macros used by the port-level checker of the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cau_pkg.sv */
// Types, constants and helper functions of the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int NUM_W      = PROD_W + FRAC_BITS;
  // Quotient bits produced by the cell row; one more than the data width.
  localparam int DIV_STEPS  = DATA_WIDTH + 1;
  localparam int REM0_W     = NUM_W - DIV_STEPS;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_PLAIN = 2'd1,
    K_DIV   = 2'd2,
    K_MAG   = 2'd3
  } kind_t;

  // Item state handed from cell to cell.
  typedef struct packed {
    logic                    valid;
    kind_t                   kind;
    logic                    dz;
    logic                    re_neg;
    logic                    im_neg;
    logic                    ovf_re;
    logic                    ovf_im;
    logic [PROD_W-1:0]       re_mag;
    logic [PROD_W-1:0]       im_mag;
    logic [PROD_W-1:0]       den;
    logic [PROD_W-1:0]       rem_re;
    logic [PROD_W-1:0]       rem_im;
    logic [DIV_STEPS-1:0]    num_re;
    logic [DIV_STEPS-1:0]    num_im;
    logic [DIV_STEPS-1:0]    q_re;
    logic [DIV_STEPS-1:0]    q_im;
    logic [PROD_W-1:0]       sq_s;
    logic [PROD_W-1:0]       sq_res;
    logic [PROD_W-1:0]       sq_bit;
  } cell_t;

  // Saturate a sign and magnitude to the data width; the top bit flags saturation.
  function automatic logic [DATA_WIDTH:0] clamp(input logic neg, input logic [PROD_W-1:0] mag);
    logic [PROD_W-1:0] lim;
    logic [DATA_WIDTH-1:0] val;
    logic sat;
    lim = PROD_W'(1) << (DATA_WIDTH - 1);
    sat = 1'b0;
    if (neg) begin
      if (mag > lim) begin
        sat = 1'b1;
        val = lim[DATA_WIDTH-1:0];
      end else begin
        val = DATA_WIDTH'(~mag[DATA_WIDTH-1:0] + DATA_WIDTH'(1));
      end
    end else begin
      if (mag > lim - PROD_W'(1)) begin
        sat = 1'b1;
        val = DATA_WIDTH'(lim - PROD_W'(1));
      end else begin
        val = mag[DATA_WIDTH-1:0];
      end
    end
    return {sat, val};
  endfunction

endpackage

/* rtl/cau_front.sv */
// Front end: products, sums and set-up of the divide and square-root cells.
`timescale 1ns / 1ps
module cau_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2:0]                          op,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_real,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_imag,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_real,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_imag,
  output cau_pkg::cell_t                      q
);
  import cau_pkg::*;

  // Stage one: six products and the add or subtract results.
  logic                         v1;
  logic [2:0]                   op1;
  logic signed [PROD_W-1:0]     p0, p1, p2, p3, p4, p5;
  logic signed [DATA_WIDTH:0]   as_re, as_im;
  logic signed [DATA_WIDTH-1:0] m0, m1;

  always_comb begin
    m0 = (op == OP_MAG) ? a_real : b_real;
    m1 = (op == OP_MAG) ? a_imag : b_imag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= op;
      p0  <= a_real * b_real;
      p1  <= a_imag * b_imag;
      p2  <= a_real * b_imag;
      p3  <= a_imag * b_real;
      p4  <= m0 * m0;
      p5  <= m1 * m1;
      if (op == OP_SUB) begin
        as_re <= (DATA_WIDTH+1)'(a_real) - (DATA_WIDTH+1)'(b_real);
        as_im <= (DATA_WIDTH+1)'(a_imag) - (DATA_WIDTH+1)'(b_imag);
      end else begin
        as_re <= (DATA_WIDTH+1)'(a_real) + (DATA_WIDTH+1)'(b_real);
        as_im <= (DATA_WIDTH+1)'(a_imag) + (DATA_WIDTH+1)'(b_imag);
      end
    end
  end

  // Stage two: combine products into sign and magnitude.
  logic                     v2;
  kind_t                    kind2;
  logic                     re_neg2, im_neg2;
  logic [PROD_W-1:0]        re_mag2, im_mag2, den2;
  logic signed [PROD_W:0]   s_re, s_im;
  logic [PROD_W:0]          a_re, a_im;
  kind_t                    kind_c;
  logic                     re_neg_c, im_neg_c;
  logic [PROD_W-1:0]        re_mag_c, im_mag_c;

  always_comb begin
    s_re = '0;
    s_im = '0;
    if (op1 == OP_MUL) begin
      s_re = (PROD_W+1)'(p0) - (PROD_W+1)'(p1);
      s_im = (PROD_W+1)'(p2) + (PROD_W+1)'(p3);
    end else begin
      s_re = (PROD_W+1)'(p0) + (PROD_W+1)'(p1);
      s_im = (PROD_W+1)'(p3) - (PROD_W+1)'(p2);
    end
    a_re = s_re[PROD_W] ? (PROD_W+1)'(-s_re) : (PROD_W+1)'(s_re);
    a_im = s_im[PROD_W] ? (PROD_W+1)'(-s_im) : (PROD_W+1)'(s_im);
    kind_c   = K_NONE;
    re_neg_c = 1'b0;
    im_neg_c = 1'b0;
    re_mag_c = '0;
    im_mag_c = '0;
    case (op1)
      OP_ADD, OP_SUB: begin
        kind_c   = K_PLAIN;
        re_neg_c = as_re[DATA_WIDTH];
        im_neg_c = as_im[DATA_WIDTH];
        re_mag_c = PROD_W'(as_re[DATA_WIDTH] ? -as_re : as_re);
        im_mag_c = PROD_W'(as_im[DATA_WIDTH] ? -as_im : as_im);
      end
      OP_MUL: begin
        kind_c   = K_PLAIN;
        re_neg_c = s_re[PROD_W];
        im_neg_c = s_im[PROD_W];
        re_mag_c = PROD_W'(a_re >> FRAC_BITS);
        im_mag_c = PROD_W'(a_im >> FRAC_BITS);
      end
      OP_DIV: begin
        kind_c   = K_DIV;
        re_neg_c = s_re[PROD_W];
        im_neg_c = s_im[PROD_W];
        re_mag_c = a_re[PROD_W-1:0];
        im_mag_c = a_im[PROD_W-1:0];
      end
      OP_MAG: begin
        kind_c = K_MAG;
      end
      default: begin
        kind_c = K_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind2   <= kind_c;
      re_neg2 <= re_neg_c;
      im_neg2 <= im_neg_c;
      re_mag2 <= re_mag_c;
      im_mag2 <= im_mag_c;
      den2    <= PROD_W'($unsigned(p4)) + PROD_W'($unsigned(p5));
    end
  end

  // Stage three: shifted numerators, overflow test and initial cell state.
  logic [NUM_W-1:0] n_re, n_im;
  cell_t            c;

  always_comb begin
    n_re       = NUM_W'(re_mag2) << FRAC_BITS;
    n_im       = NUM_W'(im_mag2) << FRAC_BITS;
    c.valid    = v2;
    c.kind     = kind2;
    c.dz       = (den2 == '0);
    c.re_neg   = re_neg2;
    c.im_neg   = im_neg2;
    c.ovf_re   = PROD_W'(n_re[NUM_W-1:DIV_STEPS]) >= den2;
    c.ovf_im   = PROD_W'(n_im[NUM_W-1:DIV_STEPS]) >= den2;
    c.re_mag   = re_mag2;
    c.im_mag   = im_mag2;
    c.den      = den2;
    c.rem_re   = PROD_W'(n_re[NUM_W-1:DIV_STEPS]);
    c.rem_im   = PROD_W'(n_im[NUM_W-1:DIV_STEPS]);
    c.num_re   = n_re[DIV_STEPS-1:0];
    c.num_im   = n_im[DIV_STEPS-1:0];
    c.q_re     = '0;
    c.q_im     = '0;
    c.sq_s     = den2;
    c.sq_res   = '0;
    c.sq_bit   = PROD_W'(1) << (PROD_W - 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= c.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.kind   <= c.kind;
      q.dz     <= c.dz;
      q.re_neg <= c.re_neg;
      q.im_neg <= c.im_neg;
      q.ovf_re <= c.ovf_re;
      q.ovf_im <= c.ovf_im;
      q.re_mag <= c.re_mag;
      q.im_mag <= c.im_mag;
      q.den    <= c.den;
      q.rem_re <= c.rem_re;
      q.rem_im <= c.rem_im;
      q.num_re <= c.num_re;
      q.num_im <= c.num_im;
      q.q_re   <= c.q_re;
      q.q_im   <= c.q_im;
      q.sq_s   <= c.sq_s;
      q.sq_res <= c.sq_res;
      q.sq_bit <= c.sq_bit;
    end
  end

endmodule

/* rtl/cau_cell.sv */
// One cell of the row: a restoring divide step per lane and a square-root step.
`timescale 1ns / 1ps
module cau_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  cau_pkg::cell_t d,
  output cau_pkg::cell_t q
);
  import cau_pkg::*;

  logic [PROD_W:0]   r2_re, r2_im, r2_re_sub, r2_im_sub;
  logic              ge_re, ge_im;
  logic [PROD_W-1:0] trial;
  cell_t             n;

  always_comb begin
    n = d;
    // Divide step: bring down one numerator bit and try the divisor.
    r2_re     = {d.rem_re, d.num_re[DIV_STEPS-1]};
    r2_im     = {d.rem_im, d.num_im[DIV_STEPS-1]};
    r2_re_sub = r2_re - {1'b0, d.den};
    r2_im_sub = r2_im - {1'b0, d.den};
    ge_re     = r2_re >= {1'b0, d.den};
    ge_im     = r2_im >= {1'b0, d.den};
    n.rem_re  = ge_re ? r2_re_sub[PROD_W-1:0] : r2_re[PROD_W-1:0];
    n.rem_im  = ge_im ? r2_im_sub[PROD_W-1:0] : r2_im[PROD_W-1:0];
    n.num_re  = d.num_re << 1;
    n.num_im  = d.num_im << 1;
    n.q_re    = {d.q_re[DIV_STEPS-2:0], ge_re};
    n.q_im    = {d.q_im[DIV_STEPS-2:0], ge_im};
    // Square-root step, idle once the trial bit has run out.
    trial = d.sq_res + d.sq_bit;
    if (d.sq_bit != '0) begin
      if (d.sq_s >= trial) begin
        n.sq_s   = d.sq_s - trial;
        n.sq_res = (d.sq_res >> 1) + d.sq_bit;
      end else begin
        n.sq_res = d.sq_res >> 1;
      end
      n.sq_bit = d.sq_bit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= n.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.kind   <= n.kind;
      q.dz     <= n.dz;
      q.re_neg <= n.re_neg;
      q.im_neg <= n.im_neg;
      q.ovf_re <= n.ovf_re;
      q.ovf_im <= n.ovf_im;
      q.re_mag <= n.re_mag;
      q.im_mag <= n.im_mag;
      q.den    <= n.den;
      q.rem_re <= n.rem_re;
      q.rem_im <= n.rem_im;
      q.num_re <= n.num_re;
      q.num_im <= n.num_im;
      q.q_re   <= n.q_re;
      q.q_im   <= n.q_im;
      q.sq_s   <= n.sq_s;
      q.sq_res <= n.sq_res;
      q.sq_bit <= n.sq_bit;
    end
  end

endmodule

/* rtl/complex_arithmetic_unit.sv */
// Top level of the complex arithmetic unit: front end, cell row and output register.
//
//   channel | signals                                   | direction
//   input   | in_valid, in_ready, op, a_*, b_*           | into block
//   output  | out_valid, out_ready, res_*, status        | out of block
//
// One transfer is accepted per cycle while the output is not stalled; a result passes
// through 37 register stages: three front stages, 33 cells, one output register.
// The row length follows from the 33 quotient bits, one per cell.
// Reset clears all valid bits; no item is in flight after reset.
// A stalled output freezes the whole pipeline and drops in_ready in the same cycle.
`timescale 1ns / 1ps
module complex_arithmetic_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          op,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_real,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_imag,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_real,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_imag,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_real,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_imag,
  output logic [1:0]                          status
);
  import cau_pkg::*;

  logic  en;
  cell_t row [DIV_STEPS+1];

  // The pipeline moves whenever the output register is free or being emptied.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  cau_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(in_valid),
    .op      (op),
    .a_real  (a_real),
    .a_imag  (a_imag),
    .b_real  (b_real),
    .b_imag  (b_imag),
    .q       (row[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    cau_cell u_cell (
      .clk(clk),
      .rst(rst),
      .en (en),
      .d  (row[i]),
      .q  (row[i+1])
    );
  end

  // Final selection and saturation.
  cell_t                 last;
  logic [PROD_W-1:0]     mag_re, mag_im;
  logic                  neg_re, neg_im;
  logic [DATA_WIDTH:0]   c_re, c_im;
  logic [DATA_WIDTH-1:0] r_re, r_im;
  logic [1:0]            st;

  always_comb begin
    last   = row[DIV_STEPS];
    mag_re = '0;
    mag_im = '0;
    neg_re = 1'b0;
    neg_im = 1'b0;
    case (last.kind)
      K_PLAIN: begin
        mag_re = last.re_mag;
        mag_im = last.im_mag;
        neg_re = last.re_neg;
        neg_im = last.im_neg;
      end
      K_DIV: begin
        mag_re = last.ovf_re ? '1 : PROD_W'(last.q_re);
        mag_im = last.ovf_im ? '1 : PROD_W'(last.q_im);
        neg_re = last.re_neg;
        neg_im = last.im_neg;
      end
      K_MAG: begin
        mag_re = last.sq_res;
      end
      default: begin
        mag_re = '0;
      end
    endcase
    c_re = clamp(neg_re, mag_re);
    c_im = clamp(neg_im, mag_im);
    r_re = c_re[DATA_WIDTH-1:0];
    r_im = c_im[DATA_WIDTH-1:0];
    st   = (c_re[DATA_WIDTH] || c_im[DATA_WIDTH]) ? ST_SAT : ST_OK;
    if (last.kind == K_DIV && last.dz) begin
      r_re = '0;
      r_im = '0;
      st   = ST_DZ;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_real <= r_re;
      res_imag <= r_im;
      status   <= st;
    end
  end

endmodule

/* rtl/cau_checker.sv */
// Port-level checker for the complex arithmetic unit and its bind.
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_assert.svh"
module cau_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [cau_pkg::DATA_WIDTH-1:0] res_real,
  input logic signed [cau_pkg::DATA_WIDTH-1:0] res_imag,
  input logic [1:0]                          status
);
  import cau_pkg::*;

  // A result that is not taken stays offered with the same payload.
  `CAU_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(res_real) && $stable(res_imag) && $stable(status), "stalled result changed")
  // The status code never takes its unused value.
  `CAU_ASSERT(a_status, out_valid |-> status != 2'd3, "unused status code")
  // A zero divisor yields zero result fields.
  `CAU_ASSERT(a_dz_zero, out_valid && status == ST_DZ |-> res_real == '0 && res_imag == '0, "divide by zero with nonzero result")
  // Nothing is offered right after reset.
  `CAU_ASSERT_ALWAYS(a_reset, rst |=> !out_valid, "result offered after reset")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .res_real (res_real),
  .res_imag (res_imag),
  .status   (status)
);

/* dv/complex_arithmetic_unit_checker.sv */
// Checker for the complex arithmetic unit: predicts each answer and compares it.
`timescale 1ns / 1ps
module complex_arithmetic_unit_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [2:0]                  op,
  input  logic signed [31:0]          a_real,
  input  logic signed [31:0]          a_imag,
  input  logic signed [31:0]          b_real,
  input  logic signed [31:0]          b_imag,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [31:0]          res_real,
  input  logic signed [31:0]          res_imag,
  input  logic [1:0]                  status,
  output int                          fail_count,
  output int                          outstanding
);
  import cau_pkg::*;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } answer_t;

  answer_t answer_q[$];

  // Saturates a sign and magnitude to 32 bits; flags saturation.
  function automatic logic [31:0] saturate(input logic neg, input logic [127:0] mag,
                                           inout logic sat);
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-mag);
    end
    if (mag > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  // Floor of the square root of a 64-bit value.
  function automatic logic [63:0] root_floor(input logic [63:0] s);
    logic [63:0] acc;
    logic [63:0] bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= acc + bitv) begin
        s = s - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  // Computes the expected answer of one operation.
  function automatic answer_t complex_op(input logic [2:0] code, input logic signed [31:0] ar,
                                         input logic signed [31:0] ai,
                                         input logic signed [31:0] br,
                                         input logic signed [31:0] bi);
    answer_t ans;
    logic signed [127:0] xr, xi, yr, yi, sre, sim;
    logic [127:0] mre, mim, den;
    logic nre, nim, sat;
    xr = ar; xi = ai; yr = br; yi = bi;
    ans.re = 0; ans.im = 0; ans.st = ST_OK;
    sat = 1'b0;
    sre = 0; sim = 0;
    case (code)
      OP_ADD: begin
        sre = xr + yr;
        sim = xi + yi;
      end
      OP_SUB: begin
        sre = xr - yr;
        sim = xi - yi;
      end
      OP_MUL: begin
        sre = xr * yr - xi * yi;
        sim = xr * yi + xi * yr;
      end
      OP_DIV: begin
        sre = xr * yr + xi * yi;
        sim = xi * yr - xr * yi;
      end
      OP_MAG: begin
        sre = 128'(root_floor(64'(xr * xr + xi * xi)));
      end
      default: return ans;
    endcase
    nre = sre < 0;
    nim = sim < 0;
    mre = nre ? -sre : sre;
    mim = nim ? -sim : sim;
    if (code == OP_MUL) begin
      mre = mre >> FRAC_BITS;
      mim = mim >> FRAC_BITS;
    end else if (code == OP_DIV) begin
      if (br == 0 && bi == 0) begin
        ans.st = ST_DZ;
        return ans;
      end
      den = yr * yr + yi * yi;
      mre = (mre << FRAC_BITS) / den;
      mim = (mim << FRAC_BITS) / den;
    end
    // A magnitude that truncates to zero carries no sign.
    if (mre == 0) nre = 1'b0;
    if (mim == 0) nim = 1'b0;
    ans.re = saturate(nre, mre, sat);
    ans.im = saturate(nim, mim, sat);
    if (sat) ans.st = ST_SAT;
    return ans;
  endfunction

  // Queues a prediction for each input transfer and checks each output transfer.
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result re=%h im=%h st=%0d", $time, res_real,
                   res_imag, status);
          fail_count <= fail_count + 1;
        end else begin
          want = answer_q.pop_front();
          if (want.re !== res_real || want.im !== res_imag || want.st !== status) begin
            $display("%0t: expected re=%h im=%h st=%0d, actual re=%h im=%h st=%0d",
                     $time, want.re, want.im, want.st, res_real, res_imag, status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        answer_q.push_back(complex_op(op, a_real, a_imag, b_real, b_imag));
      outstanding <= answer_q.size();
    end
  end

endmodule

/* dv/testbench.sv */
// Top of the complex arithmetic unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import cau_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] op = '0;
  logic signed [31:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] res_real, res_imag;
  logic [1:0] status;
  int fail_count;
  int outstanding;
  bit long_hold = 1'b0;
  bit steady = 1'b0;

  complex_arithmetic_unit u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
    .out_valid(out_valid), .out_ready(out_ready), .res_real(res_real),
    .res_imag(res_imag), .status(status)
  );

  complex_arithmetic_unit_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
    .out_valid(out_valid), .out_ready(out_ready), .res_real(res_real),
    .res_imag(res_imag), .status(status), .fail_count(fail_count),
    .outstanding(outstanding)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length: mostly short, now and then long.
  function automatic int gap_len();
    if (steady) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 2);
  endfunction

  // Operand values: full range, small magnitudes, the extremes and plus or minus one.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      7:          return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      8:          return 32'($signed($urandom_range(0, 6)) - 3);
      default:    return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
    endcase
  endfunction

  // Offers one operation after a random gap and holds it until the transfer.
  task automatic offer(input logic [2:0] code, input logic [31:0] ar, input logic [31:0] ai,
                       input logic [31:0] br, input logic [31:0] bi);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    a_real <= ar;
    a_imag <= ai;
    b_real <= br;
    b_imag <= bi;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  always @(posedge clk) begin
    int hold;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
      for (hold = 0; hold < 150; hold++) @(posedge clk);
      long_hold = 1'b0;
      out_ready <= 1'b1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 29) == 0) begin
      out_ready <= 1'b0;
      for (hold = $urandom_range(5, 30); hold > 0; hold--) @(posedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= $urandom_range(0, 3) != 0;
    end
  end

  // Stimulus and verdict.
  initial begin
    int n;
    int settle;
    logic [2:0] code;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every operation, zero divisor, unused codes, saturation.
    offer(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    offer(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    offer(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    offer(OP_SUB, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000, 32'h0003_0000);
    offer(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
    offer(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    offer(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
    offer(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
    offer(OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    offer(OP_DIV, 32'h0004_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0001_0000);
    offer(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    offer(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer(OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'h1234_5678, 32'h9ABC_DEF0);
    offer(OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    offer(OP_MAG, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(OP_MAG, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    offer(3'd5, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444);
    offer(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001);

    // Sender pause until every answer is back; the last transfer is counted first.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);

    // Random part; the receiver holds off for a long stretch at the start.
    long_hold = 1'b1;
    for (n = 0; n < 1400; n++) begin
      if (n % 200 == 100) steady = ~steady;
      code = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      offer(code, pick_value(), pick_value(), pick_value(),
            ($urandom_range(0, 15) == 0) ? 32'h0 : pick_value());
    end
    in_valid <= 1'b0;
    steady = 1'b1;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    for (settle = 0; settle < 60; settle++) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* complex_arithmetic_unit.f */
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_cell.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
dv/complex_arithmetic_unit_checker.sv
dv/testbench.sv
